[hw/rtl/prs80_pkg.sv]
// Shared types, constants and bit functions for the PRESENT-80 decrypt unit.
// No dependencies; used by every module of the block.
`default_nettype none

package prs80_pkg;

  localparam int ROUNDS    = 31;
  localparam int NUM_RK    = ROUNDS + 1;
  localparam int RK_IDX_W  = $clog2(NUM_RK);
  localparam int RC_W      = 5;
  localparam int BLOCK_W   = 64;
  localparam int KEY_W     = 80;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_UPPER = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOWER = CFG_IDX_W'(1);

  typedef logic [BLOCK_W-1:0] blk_t;
  typedef logic [KEY_W-1:0]   key_t;

  localparam logic [3:0] FWD_SBOX [16] = '{
    4'hc, 4'h5, 4'h6, 4'hb, 4'h9, 4'h0, 4'ha, 4'hd,
    4'h3, 4'he, 4'hf, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
  };
  localparam logic [3:0] INV_SBOX [16] = '{
    4'h5, 4'he, 4'hf, 4'h8, 4'hc, 4'h1, 4'h2, 4'hd,
    4'hb, 4'h4, 4'h6, 4'h3, 4'h0, 4'h7, 4'h9, 4'ha
  };

  // Output bit i takes input bit 16*i mod 63, bit 63 stays put.
  function automatic blk_t inv_perm(blk_t x);
    blk_t y;
    for (int i = 0; i < BLOCK_W; i++) begin
      y[i] = x[(i == BLOCK_W - 1) ? (BLOCK_W - 1) : ((16 * i) % (BLOCK_W - 1))];
    end
    return y;
  endfunction

  function automatic blk_t inv_sub(blk_t x);
    blk_t y;
    for (int n = 0; n < BLOCK_W / 4; n++) begin
      y[4*n +: 4] = INV_SBOX[x[4*n +: 4]];
    end
    return y;
  endfunction

  // One forward key schedule step: rotate left 61, S-box on the top
  // nibble, round counter into bits 19..15.
  function automatic key_t key_step(key_t k, logic [RC_W-1:0] rc);
    key_t t;
    t = {k[18:0], k[KEY_W-1:19]};
    t[KEY_W-1 -: 4] = FWD_SBOX[t[KEY_W-1 -: 4]];
    t[19:15] = t[19:15] ^ rc;
    return t;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/present80_block_decrypt_unit.sv]
// Top level of the PRESENT-80 block decrypt unit: key schedule, round pipeline
// and output stage. Depends on prs80_pkg, prs80_key_sched, prs80_round, prs80_out_skid.
`default_nettype none

// Usage:
//   Configuration: write the key with cfg_we/cfg_index/cfg_data. Index 0 takes
//   key bits 79..16, index 1 takes key bits 15..0 (upper data bits dropped);
//   other indexes are ignored. Write only while no item is in flight.
//   After reset and after every key write the round key bank is rebuilt,
//   one round key per cycle: in_ready stays low until the bank is full.
//   Input channel: in_valid/in_ready carry cipher_block. Output channel:
//   out_valid/out_ready carry plain_block, one item per input item, in order.
//   Path: the key add register loads on the accepting edge; the item then
//   passes the 31 round stages and leaves on plain_block from the output
//   register. Throughput: one item per cycle while the key bank is ready
//   and no stall holds the pipeline; each round stage is one register slice
//   (permutation wiring, 16 inverse S-boxes, one 64-bit XOR).
//   Stall: when out_ready is low the output register holds, one more item
//   lands in the skid entry, then the whole round pipeline freezes and
//   in_ready drops. Nothing is dropped or repeated; the pipeline resumes the
//   cycle after the skid entry drains.
//   Reset (rst, synchronous) clears all valid bits and both key registers.

module present80_block_decrypt_unit (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [prs80_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [prs80_pkg::BLOCK_W-1:0]    cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [63:0]                      cipher_block,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [63:0]                           plain_block
);

  logic            busy;
  logic            pipe_en;
  prs80_pkg::blk_t rk [prs80_pkg::NUM_RK];

  // Stage 0 is the initial key add; stages 1..ROUNDS are the rounds.
  logic            st_v [prs80_pkg::ROUNDS+1];
  prs80_pkg::blk_t st_s [prs80_pkg::ROUNDS+1];

  prs80_key_sched u_key_sched (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .busy      (busy),
    .rk        (rk)
  );

  // Accept only when the key bank is ready and the pipeline can advance.
  assign in_ready = pipe_en && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      st_v[0] <= 1'b0;
    end else if (pipe_en) begin
      st_v[0] <= in_valid && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      st_s[0] <= cipher_block ^ rk[prs80_pkg::ROUNDS];
    end
  end

  // Round r = ROUNDS - j uses round key r - 1.
  for (genvar j = 0; j < prs80_pkg::ROUNDS; j++) begin : g_round
    prs80_round u_round (
      .clk   (clk),
      .rst   (rst),
      .en    (pipe_en),
      .in_v  (st_v[j]),
      .in_s  (st_s[j]),
      .rk    (rk[prs80_pkg::ROUNDS-1-j]),
      .out_v (st_v[j+1]),
      .out_s (st_s[j+1])
    );
  end

  prs80_out_skid u_out (
    .clk       (clk),
    .rst       (rst),
    .d_valid   (st_v[prs80_pkg::ROUNDS]),
    .d_data    (st_s[prs80_pkg::ROUNDS]),
    .up_ready  (pipe_en),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (plain_block)
  );

endmodule

`default_nettype wire

[hw/rtl/prs80_key_sched.sv]
// Key registers and iterative round key expansion into a register bank.
// Depends on prs80_pkg.
`default_nettype none

module prs80_key_sched (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [prs80_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [prs80_pkg::BLOCK_W-1:0]    cfg_data,
  output logic                                  busy,
  output prs80_pkg::blk_t                       rk [prs80_pkg::NUM_RK]
);

  logic [63:0]                     key_upper;
  logic [15:0]                     key_lower;
  prs80_pkg::key_t                 kreg;
  logic [prs80_pkg::RK_IDX_W-1:0]  cnt;
  logic [prs80_pkg::RK_IDX_W:0]    cnt_inc;
  logic                            wr_upper;
  logic                            wr_lower;

  assign wr_upper = cfg_we && (cfg_index == prs80_pkg::REG_KEY_UPPER);
  assign wr_lower = cfg_we && (cfg_index == prs80_pkg::REG_KEY_LOWER);
  assign cnt_inc  = {1'b0, cnt} + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_upper <= '0;
      key_lower <= '0;
      kreg      <= '0;
      cnt       <= '0;
      busy      <= 1'b1;
    end else if (wr_upper) begin
      key_upper <= cfg_data;
      kreg      <= {cfg_data, key_lower};
      cnt       <= '0;
      busy      <= 1'b1;
    end else if (wr_lower) begin
      key_lower <= cfg_data[15:0];
      kreg      <= {key_upper, cfg_data[15:0]};
      cnt       <= '0;
      busy      <= 1'b1;
    end else if (busy) begin
      if (cnt == prs80_pkg::RK_IDX_W'(prs80_pkg::ROUNDS)) begin
        busy <= 1'b0;
      end else begin
        kreg <= prs80_pkg::key_step(kreg, prs80_pkg::RC_W'(cnt_inc));
        cnt  <= cnt_inc[prs80_pkg::RK_IDX_W-1:0];
      end
    end
  end

  // Round key bank: the top 64 bits of the key register at each step.
  // Keep filling on writes to undecoded indexes; a key write restarts the
  // fill from entry 0 anyway.
  always_ff @(posedge clk) begin
    if (busy) begin
      rk[cnt] <= kreg[prs80_pkg::KEY_W-1:16];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/prs80_round.sv]
// One registered decryption round: inverse permutation, inverse S-box, key add.
// Depends on prs80_pkg.
`default_nettype none

module prs80_round (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire logic            in_v,
  input  wire prs80_pkg::blk_t in_s,
  input  wire prs80_pkg::blk_t rk,
  output logic                 out_v,
  output prs80_pkg::blk_t      out_s
);

  prs80_pkg::blk_t s_next;

  assign s_next = prs80_pkg::inv_sub(prs80_pkg::inv_perm(in_s)) ^ rk;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_s <= s_next;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/prs80_out_skid.sv]
// Output register with a skid entry; breaks the ready path to the pipeline.
// Depends on prs80_pkg.
`default_nettype none

module prs80_out_skid (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            d_valid,
  input  wire prs80_pkg::blk_t d_data,
  output logic                 up_ready,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output prs80_pkg::blk_t      out_data
);

  logic            skid_v;
  prs80_pkg::blk_t skid_data;

  assign up_ready = !skid_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_v    <= 1'b0;
    end else if (out_ready || !out_valid) begin
      out_valid <= skid_v || d_valid;
      skid_v    <= 1'b0;
    end else if (up_ready && d_valid) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !out_valid) begin
      out_data <= skid_v ? skid_data : d_data;
    end
    if (!(out_ready || !out_valid) && up_ready && d_valid) begin
      skid_data <= d_data;
    end
  end

endmodule

`default_nettype wire
